// ===== rtl/lpmrt_pkg.sv =====
// Shared types, codes and helper functions for the longest-prefix-match route table.
package lpmrt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [5:0]  MAX_LEN   = 6'd32;
  localparam logic [31:0] FULL_MASK = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [7:0]  port;
    logic [31:0] next_hop;
    logic [7:0]  metric;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] next_hop_out;
    logic [7:0]  port_out;
    logic [7:0]  metric_out;
    logic [1:0]  status;
  } rsp_t;

  // Tag memory word: valid, saturated length, masked key
  typedef struct packed {
    logic        valid;
    logic [5:0]  len;
    logic [31:0] key;
  } tag_t;

  // Data memory word
  typedef struct packed {
    logic [7:0]  metric;
    logic [7:0]  port;
    logic [31:0] hop;
  } data_t;

  localparam int TAG_W  = $bits(tag_t);
  localparam int DATA_W = $bits(data_t);

  typedef struct packed {
    logic clear;
    logic vld;
  } scan_ctl_t;

  typedef struct packed {
    logic exact_found;
    logic free_found;
    logic best_found;
  } scan_flags_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ACT,
    S_QWAIT,
    S_DONE
  } state_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len >= MAX_LEN) begin
      m = FULL_MASK;
    end else begin
      m = (32'd1 << len) - 32'd1;
    end
    return m;
  endfunction

  function automatic logic [5:0] sat_len(input logic [5:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

endpackage

// ===== rtl/lpmrt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lpmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lpmrt_scan.sv =====
// Per-entry compare unit: tracks exact match, first free slot and longest prefix over a sweep.
module lpmrt_scan import lpmrt_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  tag_t             tag,
  input  logic [31:0]      key,
  input  logic [5:0]       len,
  input  logic [31:0]      addr,
  output scan_flags_t      flags,
  output logic [IDX_W-1:0] exact_idx,
  output logic [IDX_W-1:0] free_idx,
  output logic [IDX_W-1:0] best_idx
);

  logic [5:0] best_len;
  logic       exact_hit;
  logic       prefix_hit;

  assign exact_hit  = tag.valid && (tag.len == len) && (tag.key == key);
  assign prefix_hit = tag.valid && (((tag.key ^ addr) & len_mask(tag.len)) == 32'd0);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      flags <= '0;
    end else if (ctl.vld) begin
      if (exact_hit && !flags.exact_found) begin
        flags.exact_found <= 1'b1;
      end
      if (!tag.valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
      end
      if (prefix_hit) begin
        flags.best_found <= 1'b1;
      end
    end
  end

  // Hold indexes of the first hits; take a later prefix only if strictly longer
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      if (exact_hit && !flags.exact_found) begin
        exact_idx <= idx;
      end
      if (!tag.valid && !flags.free_found) begin
        free_idx <= idx;
      end
      if (prefix_hit && (!flags.best_found || tag.len > best_len)) begin
        best_idx <= idx;
        best_len <= tag.len;
      end
    end
  end

endmodule

// ===== rtl/lpm_route_table.sv =====
// Top level of the IPv4 longest-prefix-match route table.
//
// Request channel (req_valid / req_stall / req) carries one item per
// operation: insert, delete or query. Response channel (rsp_valid /
// rsp_stall / rsp) returns exactly one item per request, in order.
//
// Insert, delete and query sweep the tag memory once, one entry per cycle;
// the single read port of the tag memory sets this figure. After the sweep
// a drain state and an action state follow, and the result register loads;
// a query hit adds a data memory read before it. The result then moves to
// the response register, and the next item is taken only after that, so
// requests stall while an item is in work. An operation code outside
// insert/delete/query skips the sweep and returns an all-zero item.
//
// After rst the block clears the valid bits in the tag memory, one entry
// per cycle over every entry, and stalls requests during that pass.
//
// While rsp_stall is high the response holds. A finished item waits in an
// internal result register until the response register frees.
module lpm_route_table import lpmrt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             cnt_last;

  // Current item
  req_t        cur;
  logic [5:0]  cur_len;
  logic [31:0] cur_key;
  logic        take;

  // Compare pipeline: read issued this cycle, compared next cycle
  logic             rd_issue;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;

  // Memory ports
  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr;
  tag_t             tag_wdata;
  logic [TAG_W-1:0] tag_rdata;
  logic              data_we;
  logic [IDX_W-1:0]  data_waddr;
  data_t             data_wdata;
  logic [DATA_W-1:0] data_rdata;
  data_t             data_rd;

  // Scan results
  scan_ctl_t        scan_ctl;
  scan_flags_t      flags;
  logic [IDX_W-1:0] exact_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] best_idx;
  logic [IDX_W-1:0] ins_slot;

  // Result staging
  rsp_t res, res_next;
  logic res_load;
  logic rsp_load;

  assign cnt_last  = (cnt == LAST_IDX);
  assign req_stall = (state != S_IDLE);
  assign data_rd   = data_t'(data_rdata);
  assign ins_slot  = flags.exact_found ? exact_idx : free_idx;

  assign scan_ctl.clear = take;
  assign scan_ctl.vld   = cmp_vld;

  lpmrt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (cnt),
    .rdata (tag_rdata)
  );

  lpmrt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (best_idx),
    .rdata (data_rdata)
  );

  lpmrt_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .idx       (cmp_idx),
    .tag       (tag_t'(tag_rdata)),
    .key       (cur_key),
    .len       (cur_len),
    .addr      (cur.address),
    .flags     (flags),
    .exact_idx (exact_idx),
    .free_idx  (free_idx),
    .best_idx  (best_idx)
  );

  // State register and control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      cmp_vld <= rd_issue;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
    if (take) begin
      cur     <= req;
      cur_len <= sat_len(req.prefix_len);
      cur_key <= req.address & len_mask(sat_len(req.prefix_len));
    end
    if (res_load) begin
      res <= res_next;
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

  // Response valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    take       = 1'b0;
    rd_issue   = 1'b0;
    tag_we     = 1'b0;
    tag_waddr  = cnt;
    tag_wdata  = '0;
    data_we    = 1'b0;
    data_waddr = ins_slot;
    data_wdata = '{metric: cur.metric, port: cur.port, hop: cur.next_hop};
    res_next   = res;
    res_load   = 1'b0;
    rsp_load   = 1'b0;

    case (state)
      S_CLEAR: begin
        // Drop every valid bit after reset
        tag_we   = 1'b1;
        cnt_next = cnt + IDX_W'(1);
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          take     = 1'b1;
          cnt_next = '0;
          if (req.operation == OP_INSERT || req.operation == OP_DELETE ||
              req.operation == OP_QUERY) begin
            state_next = S_SCAN;
          end else begin
            res_next   = '0;
            res_load   = 1'b1;
            state_next = S_DONE;
          end
        end
      end

      S_SCAN: begin
        rd_issue = 1'b1;
        cnt_next = cnt + IDX_W'(1);
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end
      end

      S_DRAIN: begin
        // Last compare completes this cycle
        state_next = S_ACT;
      end

      S_ACT: begin
        res_next   = '0;
        res_load   = 1'b1;
        state_next = S_DONE;
        case (cur.operation)
          OP_INSERT: begin
            if (flags.exact_found || flags.free_found) begin
              tag_we    = 1'b1;
              tag_waddr = ins_slot;
              tag_wdata = '{valid: 1'b1, len: cur_len, key: cur_key};
              data_we   = 1'b1;
            end else begin
              res_next.status = ST_FULL;
            end
          end
          OP_DELETE: begin
            if (flags.exact_found) begin
              tag_we    = 1'b1;
              tag_waddr = exact_idx;
            end else begin
              res_next.status = ST_MISS;
            end
          end
          OP_QUERY: begin
            if (flags.best_found) begin
              res_load   = 1'b0;
              state_next = S_QWAIT;
            end
          end
          default: begin
          end
        endcase
      end

      S_QWAIT: begin
        res_next              = '0;
        res_next.found        = 1'b1;
        res_next.next_hop_out = data_rd.hop;
        res_next.port_out     = data_rd.port;
        res_next.metric_out   = data_rd.metric;
        res_next.status       = ST_DONE;
        res_load              = 1'b1;
        state_next            = S_DONE;
      end

      S_DONE: begin
        // Advance only when the response register frees
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lpmrt_checker.sv =====
// Port-level checker for the route table, bound to the top level.
module lpmrt_checker import lpmrt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Reset empties the response and starts the clearing pass
  a_rst_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rst_busy: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request taken during clearing pass");

  // One item at a time: acceptance is followed by a busy cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request accepted while item in work");

  // A new response only comes out while the request side is busy
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared without work in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind lpm_route_table lpmrt_checker u_lpmrt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
